// File: design/lstc_pkg.sv
// lstc_pkg: constants, register indexes and rounding helper for the
// lidar sample to Cartesian converter. No dependencies.
`default_nettype none
package lstc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STOP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TILT_TOL    = 3'd5;

    // quarter-wave polynomial coefficients, Q15
    localparam logic signed [31:0] COEF_A = 32'sd51472;
    localparam logic signed [31:0] COEF_B = 32'sd21024;
    localparam logic signed [31:0] COEF_C = 32'sd2320;

    localparam logic signed [17:0] PAN_MAX = 18'sd131071;

    typedef logic signed [49:0] prod_t;

    // round half away from zero, then shift right
    function automatic prod_t round_haz(input prod_t v, input int unsigned sh);
        prod_t half;
        prod_t mag;
        half = prod_t'(1) <<< (sh - 1);
        if (v >= 0)
        begin
            return (v + half) >>> sh;
        end
        mag = ((-v) + half) >>> sh;
        return -mag;
    endfunction

endpackage
`default_nettype wire

// File: design/lidar_sample_to_cartesian.sv
// lidar_sample_to_cartesian: converts range samples to x/y/z points with
// one shared multiplier under a small sequencer. Depends on lstc_pkg.
//
// Usage:
//   Input beats (in_valid/in_stall) carry one range sample each. The
//   running pan is reloaded from angle_start on first_of_scan and grows by
//   angle_step after every sample, saturating at 131071.
//   A rejected sample (tilt off target, pan past stop, pan outside the
//   front window, range outside limits) gives no output beat and leaves
//   the block ready, so rejected samples can follow back to back.
//   A kept sample takes four sines of 6 multiplies each plus 5 final
//   products, every multiply passing through the shared 32x18 multiplier
//   into prod_reg and then a write-back step. The HOLD state then loads the
//   output register (out_valid/out_stall). No new sample is taken until
//   the point has left the sequencer.
//   in_stall is high while a sample is in work. If the receiver stalls,
//   the finished point waits in the sequencer until the output register
//   frees, so nothing is lost.
//   Reset (rst_n low, async) clears the pan, sets the registers to their
//   defaults and empties the output. Configuration writes (wr_en,
//   wr_index, wr_data) are taken at any clock edge, no handshake.
`default_nettype none
module lidar_sample_to_cartesian #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                wr_en,
    input  wire logic [lstc_pkg::CFG_IDX_W-1:0]      wr_index,
    input  wire logic [lstc_pkg::CFG_DATA_W-1:0]     wr_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                first_of_scan,
    input  wire logic [15:0]                         range_mm,
    input  wire logic [15:0]                         intensity,
    input  wire logic [15:0]                         tilt,
    input  wire logic [15:0]                         target_tilt,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [16:0]                       x_mm,
    output logic signed [16:0]                       y_mm,
    output logic signed [16:0]                       z_mm,
    output logic [15:0]                              point_intensity
);

    localparam logic signed [31:0] TURN = 32'sd1 <<< ANGLE_BITS;
    localparam logic signed [31:0] QTR  = TURN >>> 2;
    localparam logic signed [31:0] HALF = TURN >>> 1;
    localparam logic signed [31:0] TQTR = (TURN >>> 2) * 3;
    localparam int DOWN = (ANGLE_BITS > 16) ? ANGLE_BITS - 16 : 0;
    localparam int UP   = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SIN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    // configuration
    logic signed [16:0] angle_start_reg;
    logic [15:0]        angle_step_reg;
    logic signed [17:0] angle_stop_reg;
    logic [15:0]        range_min_reg;
    logic [15:0]        range_max_reg;
    logic [15:0]        tilt_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_start_reg <= 17'sd0;
            angle_step_reg  <= 16'd182;
            angle_stop_reg  <= 18'sd65536;
            range_min_reg   <= 16'd10;
            range_max_reg   <= 16'd3000;
            tilt_tol_reg    <= 16'd182;
        end
        else if (wr_en)
        begin
            case (wr_index)
                lstc_pkg::REG_ANGLE_START: angle_start_reg <= wr_data[16:0];
                lstc_pkg::REG_ANGLE_STEP:  angle_step_reg  <= wr_data[15:0];
                lstc_pkg::REG_ANGLE_STOP:  angle_stop_reg  <= wr_data;
                lstc_pkg::REG_RANGE_MIN:   range_min_reg   <= wr_data[15:0];
                lstc_pkg::REG_RANGE_MAX:   range_max_reg   <= wr_data[15:0];
                lstc_pkg::REG_TILT_TOL:    tilt_tol_reg    <= wr_data[15:0];
                default: ;
            endcase
        end
    end

    // accept, tests and phases
    logic [1:0]         state_reg;
    logic signed [17:0] pan_accum_reg;
    logic signed [17:0] pan;
    logic signed [18:0] pan_sum;
    logic signed [17:0] pan_next;
    logic               accept;
    logic signed [16:0] tilt_diff;
    logic [16:0]        tilt_abs;
    logic               keep;
    logic signed [31:0] pan_w;
    logic signed [31:0] tilt_ang;
    logic [31:0]        pan_m;
    logic [31:0]        tilt_m;
    logic [15:0]        pan_ph;
    logic [15:0]        tilt_ph;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept = in_valid && !in_stall;

    always_comb
    begin
        pan = first_of_scan ? 18'(angle_start_reg) : pan_accum_reg;
        pan_sum = 19'(pan) + 19'(signed'({1'b0, angle_step_reg}));
        pan_next = (pan_sum > 19'(lstc_pkg::PAN_MAX)) ? lstc_pkg::PAN_MAX : pan_sum[17:0];
        tilt_diff = signed'({1'b0, tilt}) - signed'({1'b0, target_tilt});
        tilt_abs = (tilt_diff < 0) ? 17'(-tilt_diff) : 17'(tilt_diff);
        pan_w = 32'(pan);
        keep = (tilt_abs <= {1'b0, tilt_tol_reg})
            && (pan < angle_stop_reg)
            && ((pan_w < QTR) || (pan_w > TQTR))
            && (range_mm > range_min_reg) && (range_mm < range_max_reg);
        tilt_ang = HALF - signed'({16'd0, tilt});
        pan_m = 32'(pan_w & (TURN - 32'sd1));
        tilt_m = 32'(tilt_ang & (TURN - 32'sd1));
        pan_ph = 16'((pan_m >> DOWN) << UP);
        tilt_ph = 16'((tilt_m >> DOWN) << UP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_accum_reg <= 18'sd0;
        end
        else if (accept)
        begin
            pan_accum_reg <= pan_next;
        end
    end

    // sequencer and shared multiplier
    logic [15:0]        pp_reg;
    logic [15:0]        tp_reg;
    logic [15:0]        range_reg;
    logic [15:0]        inten_reg;
    logic [1:0]         sin_idx_reg;
    logic [2:0]         sub_reg;
    logic               half_reg;
    logic [14:0]        f_reg;
    logic               neg_reg;
    logic [14:0]        u2_reg;
    logic [14:0]        u3_reg;
    logic [14:0]        u5_reg;
    logic signed [32:0] acc_reg;
    logic signed [16:0] sin_reg [4];
    logic signed [31:0] t_reg;
    logic signed [16:0] xr_reg;
    logic signed [16:0] yr_reg;
    logic signed [16:0] zr_reg;
    logic signed [49:0] prod_reg;

    logic [15:0]        ph;
    logic [14:0]        f_comb;
    logic signed [31:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [49:0] mul_p;
    logic signed [32:0] v_sum;
    logic signed [32:0] v_pos;
    logic [16:0]        s_mag;
    logic signed [16:0] s_val;
    logic signed [49:0] rnd_x;
    logic signed [49:0] rnd_q30;
    logic               out_free;

    always_comb
    begin
        case (sin_idx_reg)
            2'd0: ph = pp_reg;
            2'd1: ph = pp_reg + 16'd16384;
            2'd2: ph = tp_reg;
            default: ph = tp_reg + 16'd16384;
        endcase
        f_comb = ph[14] ? 15'(15'd16384 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};

        mul_a = 32'sd0;
        mul_b = 18'sd0;
        if (state_reg == ST_SIN)
        begin
            case (sub_reg)
                3'd0:
                begin
                    mul_a = 32'(signed'({1'b0, f_comb}));
                    mul_b = 18'(signed'({1'b0, f_comb}));
                end
                3'd1:
                begin
                    mul_a = 32'(signed'({1'b0, u2_reg}));
                    mul_b = 18'(signed'({1'b0, f_reg}));
                end
                3'd2:
                begin
                    mul_a = 32'(signed'({1'b0, u3_reg}));
                    mul_b = 18'(signed'({1'b0, u2_reg}));
                end
                3'd3:
                begin
                    mul_a = lstc_pkg::COEF_A;
                    mul_b = 18'(signed'({1'b0, f_reg}));
                end
                3'd4:
                begin
                    mul_a = lstc_pkg::COEF_B;
                    mul_b = 18'(signed'({1'b0, u3_reg}));
                end
                default:
                begin
                    mul_a = lstc_pkg::COEF_C;
                    mul_b = 18'(signed'({1'b0, u5_reg}));
                end
            endcase
        end
        else
        begin
            case (sub_reg)
                3'd0:
                begin
                    mul_a = 32'(sin_reg[0]);
                    mul_b = 18'(signed'({1'b0, range_reg}));
                end
                3'd1:
                begin
                    mul_a = 32'(sin_reg[1]);
                    mul_b = 18'(sin_reg[2]);
                end
                3'd3:
                begin
                    mul_a = 32'(sin_reg[3]);
                    mul_b = 18'(sin_reg[1]);
                end
                default:
                begin
                    mul_a = t_reg;
                    mul_b = 18'(signed'({1'b0, range_reg}));
                end
            endcase
        end
        mul_p = 50'(mul_a) * 50'(mul_b);

        // quarter sine finish: clamp at zero, round to Q15, apply quadrant sign
        v_sum = acc_reg + prod_reg[32:0];
        v_pos = (v_sum < 0) ? 33'sd0 : v_sum;
        s_mag = 17'((v_pos + 33'sd8192) >>> 14);
        s_val = neg_reg ? -signed'(s_mag) : signed'(s_mag);

        rnd_x = lstc_pkg::round_haz(-prod_reg, 15);
        rnd_q30 = lstc_pkg::round_haz(prod_reg, 30);
        out_free = !out_valid || !out_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            sin_idx_reg <= 2'd0;
            sub_reg     <= 3'd0;
            half_reg    <= 1'b0;
            out_valid   <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_HOLD && out_free)
            begin
                out_valid <= 1'b1;
            end
            else if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && keep)
                    begin
                        state_reg   <= ST_SIN;
                        sin_idx_reg <= 2'd0;
                        sub_reg     <= 3'd0;
                        half_reg    <= 1'b0;
                    end
                end
                ST_SIN:
                begin
                    half_reg <= !half_reg;
                    if (half_reg)
                    begin
                        if (sub_reg == 3'd5)
                        begin
                            sub_reg <= 3'd0;
                            if (sin_idx_reg == 2'd3)
                            begin
                                state_reg <= ST_FIN;
                            end
                            sin_idx_reg <= sin_idx_reg + 2'd1;
                        end
                        else
                        begin
                            sub_reg <= sub_reg + 3'd1;
                        end
                    end
                end
                ST_FIN:
                begin
                    half_reg <= !half_reg;
                    if (half_reg)
                    begin
                        if (sub_reg == 3'd4)
                        begin
                            state_reg <= ST_HOLD;
                        end
                        sub_reg <= sub_reg + 3'd1;
                    end
                end
                default:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pp_reg    <= pan_ph;
            tp_reg    <= tilt_ph;
            range_reg <= range_mm;
            inten_reg <= intensity;
        end
        if ((state_reg == ST_SIN || state_reg == ST_FIN) && !half_reg)
        begin
            prod_reg <= mul_p;
            if (state_reg == ST_SIN && sub_reg == 3'd0)
            begin
                f_reg   <= f_comb;
                neg_reg <= ph[15];
            end
        end
        if (state_reg == ST_SIN && half_reg)
        begin
            case (sub_reg)
                3'd0: u2_reg <= prod_reg[28:14];
                3'd1: u3_reg <= prod_reg[28:14];
                3'd2: u5_reg <= prod_reg[28:14];
                3'd3: acc_reg <= prod_reg[32:0];
                3'd4: acc_reg <= acc_reg - prod_reg[32:0];
                default: sin_reg[sin_idx_reg] <= s_val;
            endcase
        end
        if (state_reg == ST_FIN && half_reg)
        begin
            case (sub_reg)
                3'd0: xr_reg <= rnd_x[16:0];
                3'd2: yr_reg <= rnd_q30[16:0];
                3'd4: zr_reg <= rnd_q30[16:0];
                default: t_reg <= prod_reg[31:0];
            endcase
        end
        if (state_reg == ST_HOLD && out_free)
        begin
            x_mm            <= xr_reg;
            y_mm            <= yr_reg;
            z_mm            <= zr_reg;
            point_intensity <= inten_reg;
        end
    end

endmodule
`default_nettype wire

// File: sim/lstc_checker.sv
// lstc_checker: watches the config port and both beat channels of
// lidar_sample_to_cartesian, predicts each point and compares it.
// Depends on lstc_pkg for register indexes and port widths.
module lstc_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [lstc_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [lstc_pkg::CFG_DATA_W-1:0]    wr_data,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               first_of_scan,
    input  logic [15:0]                        range_mm,
    input  logic [15:0]                        intensity,
    input  logic [15:0]                        tilt,
    input  logic [15:0]                        target_tilt,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic signed [16:0]                 x_mm,
    input  logic signed [16:0]                 y_mm,
    input  logic signed [16:0]                 z_mm,
    input  logic [15:0]                        point_intensity,
    output int                                 pending,
    output int                                 fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] z;
        logic [15:0] inten;
    } point_t;

    point_t points_due[$];

    longint start_ang, step_ang, stop_ang, rng_lo, rng_hi, tilt_tol;
    longint pan_acc;

    initial
    begin
        fail_count = 0;
        pending = 0;
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // quarter wave polynomial, f in 0..16384 -> Q15 magnitude
    function automatic longint quarter_wave(input longint f);
        longint u2, u3, u5, v;
        u2 = (f * f) >>> 14;
        u3 = (u2 * f) >>> 14;
        u5 = (u3 * u2) >>> 14;
        v = 51472 * f - 21024 * u3 + 2320 * u5;
        if (v < 0)
        begin
            v = 0;
        end
        return (v + 8192) >>> 14;
    endfunction

    function automatic longint sin_q15(input logic [15:0] ph);
        longint s;
        longint f;
        f = longint'(ph[13:0]);
        s = ph[14] ? quarter_wave(16384 - f) : quarter_wave(f);
        return ph[15] ? -s : s;
    endfunction

    function automatic longint round_away(input longint v, input int sh);
        longint half;
        half = longint'(1) <<< (sh - 1);
        if (v >= 0)
        begin
            return (v + half) >>> sh;
        end
        return -(((-v) + half) >>> sh);
    endfunction

    task automatic predict_point();
        longint pan, diff, rng, sp, cp, st, ct;
        logic [15:0] pp, tp;
        bit keep;
        point_t pt;
        if (first_of_scan)
        begin
            pan_acc = start_ang;
        end
        pan = pan_acc;
        rng = longint'(range_mm);
        diff = longint'(tilt) - longint'(target_tilt);
        if (diff < 0)
        begin
            diff = -diff;
        end
        keep = (diff <= tilt_tol) && (pan < stop_ang) && (pan < 16384 || pan > 49152)
            && (rng > rng_lo) && (rng < rng_hi);
        if (keep)
        begin
            pp = 16'(pan);
            tp = 16'(32768 - longint'(tilt));
            sp = sin_q15(pp);
            cp = sin_q15(pp + 16'd16384);
            st = sin_q15(tp);
            ct = sin_q15(tp + 16'd16384);
            pt.x = 17'(round_away(-(sp * rng), 15));
            pt.y = 17'(round_away(cp * st * rng, 30));
            pt.z = 17'(round_away(ct * cp * rng, 30));
            pt.inten = intensity;
            points_due = {points_due, pt};
        end
        pan_acc = pan_acc + step_ang;
        if (pan_acc > 131071)
        begin
            pan_acc = 131071;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_ang = 0;
            step_ang = 182;
            stop_ang = 65536;
            rng_lo = 10;
            rng_hi = 3000;
            tilt_tol = 182;
            pan_acc = 0;
        end
        else
        begin
            // a beat sees the registers as they were before this edge
            if (in_valid && !in_stall)
            begin
                predict_point();
            end
            if (wr_en)
            begin
                case (wr_index)
                    lstc_pkg::REG_ANGLE_START:
                        start_ang = longint'(signed'(wr_data[16:0]));
                    lstc_pkg::REG_ANGLE_STEP:  step_ang = longint'(wr_data[15:0]);
                    lstc_pkg::REG_ANGLE_STOP:
                        stop_ang = longint'(signed'(wr_data[17:0]));
                    lstc_pkg::REG_RANGE_MIN:   rng_lo = longint'(wr_data[15:0]);
                    lstc_pkg::REG_RANGE_MAX:   rng_hi = longint'(wr_data[15:0]);
                    lstc_pkg::REG_TILT_TOL:    tilt_tol = longint'(wr_data[15:0]);
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (points_due.size() == 0)
                begin
                    report("unexpected point x", longint'(x_mm), 0);
                end
                else
                begin
                    point_t e;
                    e = points_due.pop_front();
                    if (x_mm !== e.x)
                        report("x_mm", longint'(x_mm), longint'(signed'(e.x)));
                    if (y_mm !== e.y)
                        report("y_mm", longint'(y_mm), longint'(signed'(e.y)));
                    if (z_mm !== e.z)
                        report("z_mm", longint'(z_mm), longint'(signed'(e.z)));
                    if (point_intensity !== e.inten)
                        report("point_intensity", longint'(point_intensity),
                               longint'(e.inten));
                end
            end
            pending = points_due.size();
        end
    end

endmodule

// File: sim/testbench.sv
// testbench: stimulus, config writes, idle patterns and verdict for
// lidar_sample_to_cartesian. Depends on lstc_pkg and lstc_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 80;

    logic clk, rst_n;
    logic wr_en;
    logic [lstc_pkg::CFG_IDX_W-1:0] wr_index;
    logic [lstc_pkg::CFG_DATA_W-1:0] wr_data;
    logic in_valid, in_stall, first_of_scan;
    logic [15:0] range_mm, intensity, tilt, target_tilt;
    logic out_valid, out_stall;
    logic signed [16:0] x_mm, y_mm, z_mm;
    logic [15:0] point_intensity;
    int pending, fail_count;

    int send_gap_pct, stall_pct, quiet_cycles;
    int scan_left;
    longint c_lo, c_hi, c_tol;

    lidar_sample_to_cartesian dut (.*);
    lstc_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL lidar_sample_to_cartesian");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [lstc_pkg::CFG_IDX_W-1:0] idx, input longint val);
        @(negedge clk);
        in_valid = 1'b0;
        wr_en = 1'b1;
        wr_index = idx;
        wr_data = val[lstc_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    task automatic write_all(input longint st, input longint sp, input longint so,
                             input longint lo, input longint hi, input longint tol);
        write_reg(lstc_pkg::REG_ANGLE_START, st);
        write_reg(lstc_pkg::REG_ANGLE_STEP, sp);
        write_reg(lstc_pkg::REG_ANGLE_STOP, so);
        write_reg(lstc_pkg::REG_RANGE_MIN, lo);
        write_reg(lstc_pkg::REG_RANGE_MAX, hi);
        write_reg(lstc_pkg::REG_TILT_TOL, tol);
        c_lo = lo;
        c_hi = hi;
        c_tol = tol;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one sample beat, held until accepted; valid stays up for the next beat
    task automatic send_sample(input logic fos, input longint rng, input longint inten,
                               input longint tl, input longint tgt);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        first_of_scan = fos;
        range_mm = 16'(rng);
        intensity = 16'(inten);
        tilt = 16'(tl);
        target_tilt = 16'(tgt);
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
    endtask

    // mostly samples that pass the range and tilt tests, some raw noise
    task automatic random_sample();
        longint rng, tgt, tl, d;
        logic fos;
        fos = 1'b0;
        if (scan_left == 0)
        begin
            fos = 1'b1;
            scan_left = $urandom_range(4, 40);
        end
        scan_left--;
        if ($urandom_range(0, 99) < 80)
        begin
            rng = (c_lo + 1 < c_hi) ? longint'($urandom_range(c_lo + 1, c_hi - 1))
                                     : longint'($urandom_range(0, 65535));
            tgt = $urandom_range(0, 65535);
            d = $urandom_range(0, (c_tol > 65535) ? 65535 : c_tol);
            tl = $urandom_range(0, 1) ? tgt + d : tgt - d;
            if (tl < 0) tl = 0;
            if (tl > 65535) tl = 65535;
        end
        else
        begin
            rng = $urandom_range(0, 65535);
            tgt = $urandom_range(0, 65535);
            tl = $urandom_range(0, 65535);
        end
        send_sample(fos, rng, $urandom_range(0, 65535), tl, tgt);
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        in_valid = 1'b0;
        first_of_scan = 1'b0;
        range_mm = '0;
        intensity = '0;
        tilt = '0;
        target_tilt = '0;
        out_stall = 1'b0;
        send_gap_pct = 14;
        stall_pct = 55;
        quiet_cycles = 0;
        scan_left = 0;
        c_lo = 10;
        c_hi = 3000;
        c_tol = 182;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults; pan runs from 0 without a start mark
        send_sample(1'b0, 11, 0, 0, 0);
        send_sample(1'b0, 2999, 65535, 65535, 65535);
        send_sample(1'b0, 10, 1, 1000, 1000);
        send_sample(1'b0, 3000, 2, 1000, 1000);
        send_sample(1'b0, 0, 3, 500, 500);
        send_sample(1'b0, 65535, 4, 500, 500);
        send_sample(1'b0, 1500, 5, 1182, 1000);
        send_sample(1'b0, 1500, 6, 1183, 1000);
        send_sample(1'b0, 1500, 7, 818, 1000);
        send_sample(1'b1, 2000, 8, 32768, 32768);
        wait_drained();

        // widest limits, most negative start, tiny step
        write_all(-65536, 1, 131071, 0, 65535, 65535);
        send_sample(1'b1, 1, 9, 0, 65535);
        send_sample(1'b0, 65534, 10, 65535, 0);
        send_sample(1'b0, 40000, 11, 16384, 16384);
        wait_drained();
        // window edges: quarter and three quarter turn
        write_all(16383, 1, 131071, 0, 65535, 65535);
        send_sample(1'b1, 5000, 12, 100, 100);
        send_sample(1'b0, 5000, 13, 100, 100);
        wait_drained();
        write_all(49152, 1, 131071, 0, 65535, 65535);
        send_sample(1'b1, 5000, 14, 100, 100);
        send_sample(1'b0, 5000, 15, 49152, 100);
        wait_drained();
        // largest step saturates the pan; everything rejected
        write_all(65535, 65535, -65536, 65535, 0, 0);
        send_sample(1'b1, 100, 16, 0, 0);
        send_sample(1'b0, 100, 17, 0, 0);
        send_sample(1'b0, 100, 18, 0, 0);
        write_all(-16384, 65535, 131071, 0, 65535, 65535);
        send_sample(1'b0, 30000, 19, 7, 8);
        send_sample(1'b1, 30000, 20, 7, 8);
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            send_gap_pct = (ph == 0) ? 14 : (ph == 1) ? 55 : 0;
            stall_pct = (ph == 0) ? 55 : (ph == 1) ? 14 : 0;
            for (int b = 0; b < 2; b++)
            begin
                write_all(longint'($urandom_range(0, 36000)) - 20000,
                          $urandom_range(1, 3000),
                          ($urandom_range(0, 3) == 0) ? longint'($urandom_range(0, 196607)) - 65536
                                                      : 131071,
                          $urandom_range(0, 200), $urandom_range(1000, 65535),
                          $urandom_range(0, 2000));
                scan_left = 0;
                for (int i = 0; i < 72; i++)
                begin
                    random_sample();
                end
                wait_drained();
            end
        end

        if (fail_count == 0 && pending == 0)
        begin
            $display("PASS lidar_sample_to_cartesian");
        end
        else
        begin
            $display("FAIL lidar_sample_to_cartesian");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/lstc_pkg.sv
design/lidar_sample_to_cartesian.sv
sim/lstc_checker.sv
sim/testbench.sv
